### hw/rtl/lamp_blink_pattern_level_assert.svh
// Assertion macros for the lamp blink pattern level block.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef LAMP_BLINK_PATTERN_LEVEL_ASSERT_SVH
`define LAMP_BLINK_PATTERN_LEVEL_ASSERT_SVH

// Property that must hold on every clock outside reset
`define LBP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication outside reset
`define LBP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lbp_pkg.sv
// Shared types, constants and table builder for the lamp blink pattern level block.
// No dependencies; imported by every module of the block.
package lbp_pkg;

    // Phase and sine table geometry (sine entries must be a power of two)
    localparam int PHASE_BITS   = 16;
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
    localparam int QTR_BITS     = SINE_BITS - 2;
    localparam int QTR_ENTRIES  = SINE_ENTRIES / 4;
    localparam int ADDR_W       = QTR_BITS + 1;
    localparam int TIME_SHIFT   = 28 - PHASE_BITS;

    // Hash finalizer multipliers
    localparam logic [31:0] MIX_C1 = 32'h85ebca6b;
    localparam logic [31:0] MIX_C2 = 32'hc2b2ae35;

    // Level and output mapping constants, Q0.16 / Q1.16
    localparam logic [16:0] ONE_Q16    = 17'd65536;
    localparam logic [16:0] HALF_Q16   = 17'd32768;
    localparam logic [16:0] OPA_MIN    = 17'd11796;
    localparam logic [15:0] OPA_SPAN   = 16'd40633;
    localparam logic [16:0] OPA_MAX    = 17'd52429;
    localparam logic [16:0] SCALE_MIN  = 17'd47186;
    localparam logic [15:0] SCALE_SPAN = 16'd36700;
    localparam logic [16:0] SCALE_MAX  = 17'd83886;

    // Quarter-wave sine polynomial coefficients, Q30
    localparam logic [63:0] SC1 = 64'd1686629713;
    localparam logic [63:0] SC3 = 64'd693598667;
    localparam logic [63:0] SC5 = 64'd85569306;
    localparam logic [63:0] SC7 = 64'd5026995;
    localparam logic [63:0] SC9 = 64'd172272;

    typedef logic [PHASE_BITS-1:0] phase_t;

    typedef enum logic [1:0] {
        MODE_STEADY = 2'd0,
        MODE_STROBE = 2'd1,
        MODE_PULSE  = 2'd2,
        MODE_CHASE  = 2'd3
    } mode_t;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        SEL_MODE  = 3'd0,
        SEL_RATE  = 3'd1,
        SEL_PHASE = 3'd2,
        SEL_DUTY  = 3'd3,
        SEL_FLOOR = 3'd4
    } cfg_sel_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] rate;
        logic [15:0] phase;
        logic [15:0] duty;
        logic [15:0] floor_frac;
    } cfg_t;

    typedef logic [15:0] half_tab_t [QTR_ENTRIES+1];

    // sin(pi/2 * u), u in Q30, truncating shifts
    function automatic logic [63:0] quarter_sine(input logic [63:0] u);
        logic [63:0] u2;
        logic [63:0] t;
        u2 = (u * u) >> 30;
        t  = SC9;
        t  = SC7 - ((u2 * t) >> 30);
        t  = SC5 - ((u2 * t) >> 30);
        t  = SC3 - ((u2 * t) >> 30);
        t  = SC1 - ((u2 * t) >> 30);
        return (u * t) >> 30;
    endfunction

    // Half-swing of the raised sine over one quarter turn, both ends included
    function automatic half_tab_t build_half_tab();
        half_tab_t   tab;
        logic [63:0] f;
        logic [63:0] s;
        logic [63:0] half;
        for (int jj = 0; jj <= QTR_ENTRIES; jj++)
        begin
            f    = 64'(jj) << (30 - QTR_BITS);
            s    = quarter_sine(f);
            half = (s + 64'd16384) >> 15;
            if (half > 64'd32768)
            begin
                half = 64'd32768;
            end
            tab[jj] = half[15:0];
        end
        return tab;
    endfunction

endpackage

### hw/rtl/lamp_blink_pattern_level.sv
// Lamp blink pattern level: top level with config registers and output stage.
// Depends on lbp_pkg, lbp_phase, lbp_level and lamp_blink_pattern_level_assert.svh.
//
// Turns a time stamp and an entity id into a lamp level, opacity and scale.
// The block takes one transaction per clock. While a result waits at the
// output it keeps taking them until all seven stages hold one, then drops
// s_axis_tready. From input transaction to output valid a result passes
// three stages for the id hash, time * rate product and phase sum, three for
// the sine ROM read, pulse product and mode select, and the output register
// holding the opacity and scale products. The raised sine comes from a
// 257-entry quarter-wave ROM built at elaboration. Configuration
// registers feed most stages directly, so write them only while no
// transaction is in flight.
`include "lamp_blink_pattern_level_assert.svh"

module lamp_blink_pattern_level import lbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] time_seconds, [63:32] entity_id
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // [16:0] level, [33:17] opacity, [50:34] scale
);

    localparam int PIPE_DEPTH = 7;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    mode_t       mode_reg;
    logic [15:0] rate_reg;
    logic [15:0] phase_reg;
    logic [15:0] duty_reg;
    logic [15:0] floor_reg;
    cfg_t        cfg;

    logic        ph_valid;
    logic        ph_ready;
    phase_t      ph_phase;
    logic        lv_valid;
    logic        lv_ready;
    logic [16:0] lv_level;

    logic        out_vld_reg;
    logic        adv_out;
    logic [32:0] opa_rnd;
    logic [32:0] scl_rnd;
    logic [16:0] level_reg;
    logic [16:0] opacity_reg;
    logic [16:0] scale_reg;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_STEADY;
            rate_reg  <= '0;
            phase_reg <= '0;
            duty_reg  <= '0;
            floor_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_sel_t'(cfg_index))
                SEL_MODE:  mode_reg  <= mode_t'(cfg_wdata[1:0]);
                SEL_RATE:  rate_reg  <= cfg_wdata;
                SEL_PHASE: phase_reg <= cfg_wdata;
                SEL_DUTY:  duty_reg  <= cfg_wdata;
                SEL_FLOOR: floor_reg <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    assign cfg.mode       = mode_reg;
    assign cfg.rate       = rate_reg;
    assign cfg.phase      = phase_reg;
    assign cfg.duty       = duty_reg;
    assign cfg.floor_frac = floor_reg;

    lbp_phase u_phase
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_time   (s_axis_tdata[31:0]),
        .in_id     (s_axis_tdata[63:32]),
        .out_valid (ph_valid),
        .out_ready (ph_ready),
        .out_phase (ph_phase)
    );

    lbp_level u_level
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (ph_valid),
        .in_ready  (ph_ready),
        .in_phase  (ph_phase),
        .out_valid (lv_valid),
        .out_ready (lv_ready),
        .out_level (lv_level)
    );

    // Output register: level mapped to opacity and scale
    assign adv_out  = !out_vld_reg || m_axis_tready;
    assign lv_ready = adv_out;
    assign opa_rnd  = 33'(OPA_SPAN) * 33'(lv_level) + 33'd32768;
    assign scl_rnd  = 33'(SCALE_SPAN) * 33'(lv_level) + 33'd32768;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv_out)
        begin
            out_vld_reg <= lv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && lv_valid)
        begin
            level_reg   <= lv_level;
            opacity_reg <= OPA_MIN + opa_rnd[32:16];
            scale_reg   <= SCALE_MIN + scl_rnd[32:16];
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {5'b0, scale_reg, opacity_reg, level_reg};

    // Transactions in flight, for the checks below
    always_comb
    begin
        cnt_next = cnt_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            cnt_next = cnt_next + CNT_W'(1);
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            cnt_next = cnt_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Checks
    `LBP_ASSERT_ALWAYS(a_depth_bound, cnt_reg <= CNT_W'(PIPE_DEPTH), "more in flight than stages")
    `LBP_ASSERT_IMPLY(a_empty_no_out, cnt_reg == '0, !m_axis_tvalid, "output with nothing in flight")
    `LBP_ASSERT_IMPLY(a_stall_full, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")
    `LBP_ASSERT_IMPLY(a_full_map, m_axis_tvalid && (m_axis_tdata[16:0] == ONE_Q16), (m_axis_tdata[33:17] == OPA_MAX) && (m_axis_tdata[50:34] == SCALE_MAX), "full level mapped wrong")

endmodule

### hw/rtl/lbp_sine_rom.sv
// Quarter-wave raised-sine half-swing ROM with registered read.
// Contents are built at elaboration by lbp_pkg::build_half_tab.
module lbp_sine_rom import lbp_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [ADDR_W-1:0] addr,
    output logic [15:0]       data
);

    localparam half_tab_t HALF_TAB = build_half_tab();

    logic [15:0] data_reg;

    // Registered read, held while the stage is stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= HALF_TAB[addr];
        end
    end

    assign data = data_reg;

endmodule

### hw/rtl/lbp_phase.sv
// Phase pipeline: id hash, time-rate product and phase sum, three stages.
// Depends on lbp_pkg.
module lbp_phase import lbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_time,
    input  logic [31:0] in_id,
    output logic        out_valid,
    input  logic        out_ready,
    output phase_t      out_phase
);

    localparam int STAGES = 3;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] adv;

    logic [31:0] mix0;
    logic [31:0] mul1;
    logic [47:0] tprod;
    logic [31:0] h1_reg;
    phase_t      ptime1_reg;

    logic [31:0] mix1;
    logic [31:0] mul2;
    phase_t      pinst_reg;
    phase_t      ptime2_reg;

    logic [16+PHASE_BITS-1:0] lamp_wide;
    phase_t                   plamp;
    phase_t                   sum_reg;

    // Stage advance: a stage moves when empty or when its successor moves
    always_comb
    begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage 1: first hash round and time * rate
    assign mix0  = in_id ^ {16'b0, in_id[31:16]};
    assign mul1  = mix0 * MIX_C1;
    assign tprod = 48'(in_time) * 48'(cfg.rate);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            h1_reg     <= mul1;
            ptime1_reg <= tprod[TIME_SHIFT +: PHASE_BITS];
        end
    end

    // Stage 2: second hash round; the final xor leaves the top half alone
    assign mix1 = h1_reg ^ (h1_reg >> 13);
    assign mul2 = mix1 * MIX_C2;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            pinst_reg  <= mul2[31 -: PHASE_BITS];
            ptime2_reg <= ptime1_reg;
        end
    end

    // Stage 3: wrap-around phase sum
    assign lamp_wide = {cfg.phase, {PHASE_BITS{1'b0}}};
    assign plamp     = lamp_wide[16 +: PHASE_BITS];

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            sum_reg <= ptime2_reg + plamp + pinst_reg;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_phase = sum_reg;

endmodule

### hw/rtl/lbp_level.sv
// Level pipeline: duty test, sine lookup, pulse blend and mode select.
// Depends on lbp_pkg and lbp_sine_rom.
module lbp_level import lbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  phase_t      in_phase,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [16:0] out_level
);

    localparam int STAGES = 3;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] adv;

    logic                          on_now;
    logic [PHASE_BITS+SINE_BITS-1:0] k_wide;
    logic [SINE_BITS-1:0]          k_idx;
    logic [1:0]                    quad;
    logic [QTR_BITS-1:0]           j_idx;
    logic [ADDR_W-1:0]             rom_addr;
    logic [15:0]                   half;
    logic                          on_a_reg;
    logic                          neg_a_reg;

    logic [16:0] raised;
    logic [16:0] span;
    logic [33:0] prod;
    logic [33:0] prod_reg;
    logic        on_b_reg;

    logic [33:0] rnd;
    logic [17:0] pulse_sum;
    logic [16:0] pulse_lvl;
    logic [16:0] level_next;
    logic [16:0] level_reg;

    // Stage advance chain
    always_comb
    begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage A: duty compare and quarter-wave address, ROM read registered
    assign on_now = {in_phase, 16'b0} < {cfg.duty, {PHASE_BITS{1'b0}}};
    assign k_wide = {in_phase, {SINE_BITS{1'b0}}};
    assign k_idx  = k_wide[PHASE_BITS +: SINE_BITS];
    assign quad   = k_idx[SINE_BITS-1 -: 2];
    assign j_idx  = k_idx[QTR_BITS-1:0];

    // Odd quadrants run the quarter wave backwards
    assign rom_addr = quad[0] ? (ADDR_W'(QTR_ENTRIES) - {1'b0, j_idx}) : {1'b0, j_idx};

    lbp_sine_rom u_rom
    (
        .clk  (clk),
        .en   (adv[0]),
        .addr (rom_addr),
        .data (half)
    );

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            on_a_reg  <= on_now;
            neg_a_reg <= quad[1];
        end
    end

    // Stage B: raised sine and pulse product
    assign raised = neg_a_reg ? (HALF_Q16 - {1'b0, half}) : (HALF_Q16 + {1'b0, half});
    assign span   = ONE_Q16 - {1'b0, cfg.floor_frac};
    assign prod   = 34'(span) * 34'(raised);

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            prod_reg <= prod;
            on_b_reg <= on_a_reg;
        end
    end

    // Stage C: round, add floor, clamp and pick the mode
    assign rnd       = prod_reg + 34'd32768;
    assign pulse_sum = {2'b0, cfg.floor_frac} + rnd[33:16];
    assign pulse_lvl = (pulse_sum > 18'(ONE_Q16)) ? ONE_Q16 : pulse_sum[16:0];

    always_comb
    begin
        unique case (cfg.mode)
            MODE_STEADY: level_next = ONE_Q16;
            MODE_STROBE: level_next = on_b_reg ? ONE_Q16 : 17'd0;
            MODE_PULSE:  level_next = pulse_lvl;
            MODE_CHASE:  level_next = on_b_reg ? ONE_Q16 : {1'b0, cfg.floor_frac};
            default:     level_next = ONE_Q16;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            level_reg <= level_next;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_level = level_reg;

endmodule

### tb/lamp_blink_pattern_level_tb.sv
// Testbench for lamp_blink_pattern_level: directed and random transactions checked
// against a cycle-free predictor of level, opacity and scale. Depends on lbp_pkg and the DUT.
`timescale 1ns / 100ps

module lamp_blink_pattern_level_tb;
    import lbp_pkg::*;

    localparam int          LATENCY       = 7;
    localparam int          SETTLE_CYCLES = LATENCY + 3;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          ITEMS_PER_SET = 84;
    localparam logic [2:0]  IDX_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  IDX_SPARE_LAST  = 3'd7;

    // Output word as it appears on m_axis_tdata, level in the low bits
    typedef struct packed {
        logic [4:0]  pad;
        logic [16:0] scale;
        logic [16:0] opacity;
        logic [16:0] level;
    } lamp_out_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [2:0]  cfg_index     = 3'd0;
    logic [15:0] cfg_wdata     = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = 64'd0;  // [31:0] time_seconds, [63:32] entity_id
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;           // [16:0] level, [33:17] opacity, [50:34] scale

    cfg_t        lamp_cfg     = '0;
    lamp_out_t   expected_q[$];
    lamp_out_t   got_lamp;
    lamp_out_t   want_lamp;
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    int          error_count  = 0;
    int          cycle_count  = 0;

    lamp_blink_pattern_level dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // sin(pi/2 * u), Q30 in and out; odd polynomial by Horner with truncating shifts
    function automatic logic [63:0] quarter_wave(input logic [63:0] u);
        logic [63:0] u2;
        logic [63:0] acc;
        u2  = (u * u) >> 30;
        acc = SC7 - ((u2 * SC9) >> 30);
        acc = SC5 - ((u2 * acc) >> 30);
        acc = SC3 - ((u2 * acc) >> 30);
        acc = SC1 - ((u2 * acc) >> 30);
        return (u * acc) >> 30;
    endfunction

    // Raised sine 0..65536 at table slot k, mirrored per quadrant
    function automatic logic [16:0] raised_sine(input logic [SINE_BITS-1:0] k);
        logic [1:0]  quad;
        logic [63:0] frac;
        logic [63:0] swing;
        logic [16:0] half;
        quad = k[SINE_BITS-1 -: 2];
        frac = 64'(k[QTR_BITS-1:0]) << (30 - QTR_BITS);
        if (quad[0])
        begin
            frac = (64'd1 << 30) - frac;
        end
        swing = (quarter_wave(frac) + 64'd16384) >> 15;
        if (swing > 64'd32768)
        begin
            swing = 64'd32768;
        end
        half = swing[16:0];
        return quad[1] ? HALF_Q16 - half : HALF_Q16 + half;
    endfunction

    // Expected level, opacity and scale for one time / id pair under lamp_cfg
    function automatic lamp_out_t lamp_response(input logic [31:0] t_q16,
                                                 input logic [31:0] id);
        logic [31:0]          h;
        logic [47:0]          rate_prod;
        phase_t               p;
        logic [SINE_BITS-1:0] k;
        logic [33:0]          span_prod;
        logic [16:0]          lvl;
        lamp_out_t            res;
        // murmur finalizer gives the per-instance phase
        h = id ^ (id >> 16);
        h = h * MIX_C1;
        h = h ^ (h >> 13);
        h = h * MIX_C2;
        h = h ^ (h >> 16);
        rate_prod = 48'(t_q16) * 48'(lamp_cfg.rate);
        p = phase_t'(rate_prod >> TIME_SHIFT) + lamp_cfg.phase + h[31 -: PHASE_BITS];
        case (lamp_cfg.mode)
            MODE_STROBE: lvl = (p < lamp_cfg.duty) ? ONE_Q16 : 17'd0;
            MODE_CHASE:  lvl = (p < lamp_cfg.duty) ? ONE_Q16 : {1'b0, lamp_cfg.floor_frac};
            MODE_PULSE:
            begin
                k = p[PHASE_BITS-1 -: SINE_BITS];
                span_prod = 34'(ONE_Q16 - {1'b0, lamp_cfg.floor_frac}) * raised_sine(k)
                            + 34'(HALF_Q16);
                lvl = {1'b0, lamp_cfg.floor_frac} + 17'(span_prod >> 16);
            end
            default:     lvl = ONE_Q16;
        endcase
        if (lvl > ONE_Q16)
        begin
            lvl = ONE_Q16;
        end
        res.pad     = '0;
        res.level   = lvl;
        res.opacity = OPA_MIN + 17'((34'(OPA_SPAN) * lvl + 34'(HALF_Q16)) >> 16);
        res.scale   = SCALE_MIN + 17'((34'(SCALE_SPAN) * lvl + 34'(HALF_Q16)) >> 16);
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [16:0] want,
                                 input logic [16:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Result checker and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_lamp = m_axis_tdata;
                if (expected_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want_lamp = expected_q.pop_front();
                    compare_field("level", want_lamp.level, got_lamp.level);
                    compare_field("opacity", want_lamp.opacity, got_lamp.opacity);
                    compare_field("scale", want_lamp.scale, got_lamp.scale);
                    compare_field("pad", 17'(want_lamp.pad), 17'(got_lamp.pad));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // One input transaction, with random idle cycles ahead of it
    task automatic send_sample(input logic [31:0] t_q16, input logic [31:0] id);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {id, t_q16};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        expected_q = {expected_q, lamp_response(t_q16, id)};
    endtask

    // Stop sending and wait for the pipeline to empty
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write
    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        case (index)
            SEL_MODE:  lamp_cfg.mode       = mode_t'(value[1:0]);
            SEL_RATE:  lamp_cfg.rate       = value;
            SEL_PHASE: lamp_cfg.phase      = value;
            SEL_DUTY:  lamp_cfg.duty       = value;
            SEL_FLOOR: lamp_cfg.floor_frac = value;
            default:   ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [15:0] mode_word, input logic [15:0] rate,
                                input logic [15:0] phase, input logic [15:0] duty,
                                input logic [15:0] floor_frac);
        settle_idle();
        write_reg(SEL_MODE, mode_word);
        write_reg(SEL_RATE, rate);
        write_reg(SEL_PHASE, phase);
        write_reg(SEL_DUTY, duty);
        write_reg(SEL_FLOOR, floor_frac);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Reset values give steady mode; spare register indexes change nothing
    task automatic test_reset_defaults();
        send_sample(32'h0000_0000, 32'h0000_0000);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        settle_idle();
        for (logic [3:0] idx = IDX_SPARE_FIRST; idx <= IDX_SPARE_LAST; idx++)
        begin
            write_reg(idx[2:0], 16'hFFFF);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        send_sample(32'h1234_5678, 32'h9ABC_DEF0);
    endtask

    task automatic test_each_mode();
        for (int m = 0; m < 4; m++)
        begin
            apply_config(16'(mode_t'(m)), 16'h1000, 16'h4000, 16'h8000, 16'h3000);
            send_sample(32'h0000_0000, 32'h0000_0000);
            send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
            send_sample(32'h0001_8000, 32'hA5A5_5A5A);
        end
    endtask

    // Zero duty: strobe stays dark, chase rests at floor
    task automatic test_zero_duty();
        apply_config(16'(MODE_STROBE), 16'h2345, 16'h1111, 16'h0000, 16'h7000);
        send_sample(32'h0000_0000, 32'h0000_0000);
        send_sample(32'hFFFF_FFFF, 32'h0BAD_F00D);
        apply_config(16'(MODE_CHASE), 16'h2345, 16'h1111, 16'h0000, 16'h7000);
        send_sample(32'h0000_0000, 32'h0000_0000);
        send_sample(32'hFFFF_FFFF, 32'h0BAD_F00D);
    endtask

    // Zero rate leaves only lamp and instance phase; full rate with full floor
    task automatic test_rate_extremes();
        apply_config(16'(MODE_PULSE), 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_sample(32'hFFFF_FFFF, 32'h0000_0001);
        send_sample(32'h8000_0000, 32'hFFFF_FFFF);
        apply_config(16'(MODE_PULSE), 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_sample(32'hFFFF_FFFF, 32'h0000_0000);
        send_sample(32'h0000_0001, 32'h8000_0000);
    endtask

    // Upper bits of the mode word are dropped
    task automatic test_mode_masking();
        apply_config(16'hFFFE, 16'h0800, 16'h0000, 16'h4000, 16'h2000);
        send_sample(32'h0003_0000, 32'h0000_00FF);
    endtask

    // Sender holds off until every result is back, then resumes
    task automatic test_drain_pause();
        for (int n = 0; n < 30; n++)
        begin
            send_sample($urandom(), $urandom());
        end
        settle_idle();
        for (int n = 0; n < 30; n++)
        begin
            send_sample($urandom(), $urandom());
        end
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct);
        logic [31:0] t_q16;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int cfg_set = 0; cfg_set < 6; cfg_set++)
        begin
            case (cfg_set)
                0: apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: apply_config(16'(MODE_PULSE), 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                2: apply_config(16'(MODE_PULSE), 16'($urandom()), 16'($urandom()),
                                16'($urandom()), 16'hFFFF);
                default: apply_config(16'($urandom()), 16'($urandom()), 16'($urandom()),
                                      16'($urandom()), 16'($urandom()));
            endcase
            for (int n = 0; n < ITEMS_PER_SET; n++)
            begin
                t_q16 = $urandom();
                if ($urandom_range(3) == 0)
                begin
                    t_q16 = $urandom_range(65535);
                end
                send_sample(t_q16, $urandom());
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_pct  = 37;
        rx_stall_pct = 46;
        test_reset_defaults();
        test_each_mode();
        test_zero_duty();
        test_rate_extremes();
        test_mode_masking();
        test_random_traffic(37, 46);
        test_drain_pause();
        test_random_traffic(46, 37);
        test_random_traffic(0, 0);
        settle_idle();
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/lbp_pkg.sv
hw/rtl/lbp_sine_rom.sv
hw/rtl/lbp_phase.sv
hw/rtl/lbp_level.sv
hw/rtl/lamp_blink_pattern_level.sv
tb/lamp_blink_pattern_level_tb.sv
